>>> rtl/rsq_pkg.sv
`timescale 1ns / 1ps

package rsq_pkg;

  // score format
  localparam int FRAC_BITS = 16;
  localparam int SCORE_W   = 32;

  // fixed-point constants
  localparam logic [SCORE_W-1:0] ONE_Q     = 32'h0001_0000;
  localparam logic [SCORE_W-1:0] SCORE_MIN = 32'h8000_0000;
  // largest quotient that still gives a representable score: 2^31 + 1.0
  localparam logic [SCORE_W:0]   SAT_LIMIT = 33'h0_8001_0000;

endpackage

>>> rtl/rsq_front.sv
`timescale 1ns / 1ps

module rsq_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int ENTRY_W     = 5 * SAMPLE_BITS + 4 * COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_true_value,
  input  logic signed [SAMPLE_BITS-1:0] in_pred_value,
  input  logic                          in_last_item,
  output logic                          push,
  output logic [ENTRY_W-1:0]            push_data,
  input  logic                          full
);

  localparam int SB = SAMPLE_BITS;
  localparam int CB = COUNT_BITS;
  localparam int SW = SB + CB;
  localparam int QW = 2 * SB + CB;
  localparam int PW = 2 * SB;

  // square stage
  logic                 a_v_r, a_v_nxt;
  logic                 a_last_r;
  logic                 a_kept_r;
  logic signed [SB-1:0] a_t_r;
  logic [PW-1:0]        a_tsq_r;
  logic [PW-1:0]        a_dsq_r;
  logic [CB-1:0]        a_n_r;

  // open run
  logic [CB-1:0]        cnt_r, cnt_nxt;
  logic signed [SW-1:0] s_r, s_nxt, s_sum;
  logic [QW-1:0]        q_r, q_nxt, q_sum;
  logic [QW-1:0]        r_r, r_nxt, r_sum;

  logic                   accept;
  logic                   a_hold;
  logic                   a_go;
  logic                   kept;
  logic [CB-1:0]          cnt_inc;
  logic signed [SB:0]     d_ext;
  logic signed [PW+1:0]   d_prod;
  logic signed [PW-1:0]   t_prod;
  logic signed [SW-1:0]   t_ext;

  // a last pair waits in the square stage while the queue is full
  assign a_hold   = a_v_r & a_last_r & full;
  assign in_stall = a_hold;
  assign accept   = in_valid & ~in_stall;
  assign a_go     = a_v_r & ~a_hold;

  // pair counter, saturating pairs are dropped
  assign kept    = ~&cnt_r;
  assign cnt_inc = cnt_r + {{(CB-1){1'b0}}, kept};

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = in_last_item ? '0 : cnt_inc;
    end
  end

  // squares of truth and residual
  assign d_ext  = {in_true_value[SB-1], in_true_value} - {in_pred_value[SB-1], in_pred_value};
  assign d_prod = d_ext * d_ext;
  assign t_prod = in_true_value * in_true_value;

  always_comb begin
    a_v_nxt = a_v_r;
    if (!a_hold) begin
      a_v_nxt = accept;
    end
  end

  // accumulate and hand off finished runs
  assign t_ext = {{CB{a_t_r[SB-1]}}, a_t_r};
  assign s_sum = s_r + (a_kept_r ? t_ext : '0);
  assign q_sum = q_r + (a_kept_r ? QW'(a_tsq_r) : '0);
  assign r_sum = r_r + (a_kept_r ? QW'(a_dsq_r) : '0);

  assign push      = a_go & a_last_r;
  assign push_data = {a_n_r, s_sum, q_sum, r_sum};

  always_comb begin
    s_nxt = s_r;
    q_nxt = q_r;
    r_nxt = r_r;
    if (a_go) begin
      if (a_last_r) begin
        s_nxt = '0;
        q_nxt = '0;
        r_nxt = '0;
      end else begin
        s_nxt = s_sum;
        q_nxt = q_sum;
        r_nxt = r_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      cnt_r <= '0;
      s_r   <= '0;
      q_r   <= '0;
      r_r   <= '0;
    end else begin
      a_v_r <= a_v_nxt;
      cnt_r <= cnt_nxt;
      s_r   <= s_nxt;
      q_r   <= q_nxt;
      r_r   <= r_nxt;
    end
  end

  // square stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      a_last_r <= in_last_item;
      a_kept_r <= kept;
      a_t_r    <= in_true_value;
      a_tsq_r  <= $unsigned(t_prod);
      a_dsq_r  <= $unsigned(d_prod[PW-1:0]);
      a_n_r    <= cnt_inc;
    end
  end

endmodule

>>> rtl/rsq_queue.sv
`timescale 1ns / 1ps

module rsq_queue #(
  parameter int WIDTH = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       fill_r, fill_nxt;
  logic             do_wr, do_rd;

  assign full    = fill_r[1];
  assign empty   = (fill_r == 2'd0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = slot_r[rp_r];

  // fill level
  always_comb begin
    fill_nxt = fill_r;
    if (do_wr && !do_rd) begin
      fill_nxt = fill_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (do_wr) begin
        wp_r <= ~wp_r;
      end
      if (do_rd) begin
        rp_r <= ~rp_r;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule

>>> rtl/rsq_back.sv
`timescale 1ns / 1ps

module rsq_back
  import rsq_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int ENTRY_W     = 5 * SAMPLE_BITS + 4 * COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  empty,
  input  logic [ENTRY_W-1:0]    rd_data,
  output logic                  rd_en,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SCORE_W-1:0]    out_r2_score,
  output logic                  out_constant_truth,
  output logic                  out_score_saturated,
  output logic [COUNT_BITS-1:0] out_pair_count
);

  localparam int SB  = SAMPLE_BITS;
  localparam int CB  = COUNT_BITS;
  localparam int SW  = SB + CB;
  localparam int QW  = 2 * SB + CB;
  localparam int DW  = QW + CB;
  localparam int NW  = DW + FRAC_BITS + 2;
  localparam int RMW = DW + 1;
  localparam int CW  = $clog2(NW);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_SPREAD = 6'b000100,
    ST_LOAD   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CB-1:0]    n_r, n_nxt;
  logic [CB-1:0]    nsh_r, nsh_nxt;
  logic [SW-1:0]    ssh_r, ssh_nxt;
  logic [DW-1:0]    mq_r, mq_nxt;
  logic [DW-1:0]    mr_r, mr_nxt;
  logic [DW-1:0]    ms_r, ms_nxt;
  logic [DW-1:0]    nq_r, nq_nxt;
  logic [DW-1:0]    nr_r, nr_nxt;
  logic [DW-1:0]    s2_r, s2_nxt;
  logic [DW-1:0]    d_r, d_nxt;
  logic [NW-1:0]    num_r, num_nxt;
  logic [DW:0]      div_r, div_nxt;
  logic [RMW-1:0]   rem_r, rem_nxt;
  logic [SCORE_W:0] q_r, q_nxt;
  logic             qov_r, qov_nxt;
  logic             flat_r, flat_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0]   score_r;
  logic                 flat_out_r;
  logic                 sat_out_r;
  logic [CB-1:0]        count_out_r;

  logic [CB-1:0]        e_n;
  logic signed [SW-1:0] e_s;
  logic [QW-1:0]        e_q;
  logic [QW-1:0]        e_r;
  logic [SW-1:0]        s_mag;
  logic [RMW:0]         rem_sh;
  logic                 rem_ge;
  logic                 emit_go;
  logic                 sat;
  logic [SCORE_W-1:0]   score;

  assign {e_n, e_s, e_q, e_r} = rd_data;
  assign s_mag = e_s[SW-1] ? $unsigned(-e_s) : $unsigned(e_s);

  // one restoring division step
  assign rem_sh = {rem_r, num_r[NW-1]};
  assign rem_ge = (rem_sh >= (RMW+1)'(div_r));

  // final score from quotient
  assign sat   = qov_r | (q_r > SAT_LIMIT);
  assign score = flat_r ? ONE_Q : (sat ? SCORE_MIN : (ONE_Q - q_r[SCORE_W-1:0]));

  assign rd_en   = (state_r == ST_IDLE) & ~empty;
  assign emit_go = (state_r == ST_EMIT) & (~out_valid_r | ~out_stall);

  // sequencer: shift-add products, spread, long division, emit
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    nsh_nxt   = nsh_r;
    ssh_nxt   = ssh_r;
    mq_nxt    = mq_r;
    mr_nxt    = mr_r;
    ms_nxt    = ms_r;
    nq_nxt    = nq_r;
    nr_nxt    = nr_r;
    s2_nxt    = s2_r;
    d_nxt     = d_r;
    num_nxt   = num_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    qov_nxt   = qov_r;
    flat_nxt  = flat_r;
    case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          n_nxt     = e_n;
          nsh_nxt   = e_n;
          ssh_nxt   = s_mag;
          mq_nxt    = DW'(e_q);
          mr_nxt    = DW'(e_r);
          ms_nxt    = DW'(s_mag);
          nq_nxt    = '0;
          nr_nxt    = '0;
          s2_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (nsh_r[0]) begin
          nq_nxt = nq_r + mq_r;
          nr_nxt = nr_r + mr_r;
        end
        if (ssh_r[0]) begin
          s2_nxt = s2_r + ms_r;
        end
        mq_nxt  = {mq_r[DW-2:0], 1'b0};
        mr_nxt  = {mr_r[DW-2:0], 1'b0};
        ms_nxt  = {ms_r[DW-2:0], 1'b0};
        nsh_nxt = nsh_r >> 1;
        ssh_nxt = ssh_r >> 1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(SW - 1)) begin
          state_nxt = ST_SPREAD;
        end
      end
      ST_SPREAD: begin
        d_nxt     = (nq_r >= s2_r) ? (nq_r - s2_r) : '0;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        flat_nxt = (d_r == '0);
        num_nxt  = {nr_r, {(FRAC_BITS + 1){1'b0}}} + NW'(d_r);
        div_nxt  = {d_r, 1'b0};
        rem_nxt  = '0;
        q_nxt    = '0;
        qov_nxt  = 1'b0;
        cnt_nxt  = '0;
        if (d_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? RMW'(rem_sh - (RMW+1)'(div_r)) : rem_sh[RMW-1:0];
        q_nxt   = {q_r[SCORE_W-1:0], rem_ge};
        qov_nxt = qov_r | q_r[SCORE_W];
        num_nxt = {num_r[NW-2:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(NW - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    n_r    <= n_nxt;
    nsh_r  <= nsh_nxt;
    ssh_r  <= ssh_nxt;
    mq_r   <= mq_nxt;
    mr_r   <= mr_nxt;
    ms_r   <= ms_nxt;
    nq_r   <= nq_nxt;
    nr_r   <= nr_nxt;
    s2_r   <= s2_nxt;
    d_r    <= d_nxt;
    num_r  <= num_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    qov_r  <= qov_nxt;
    flat_r <= flat_nxt;
    if (emit_go) begin
      score_r     <= score;
      flat_out_r  <= flat_r;
      sat_out_r   <= ~flat_r & sat;
      count_out_r <= n_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_r2_score        = score_r;
  assign out_constant_truth  = flat_out_r;
  assign out_score_saturated = sat_out_r;
  assign out_pair_count      = count_out_r;

endmodule

>>> rtl/r_squared_score_unit_top.sv
`timescale 1ns / 1ps
// streaming r-squared: one sample pair accepted per cycle while in_stall is low; a square stage
// register feeds the run accumulators, and a last pair hands its sums to a two-entry queue;
// the finisher then runs bit-serial products and a long division on an NW-bit dividend
// (SW = SAMPLE_BITS + COUNT_BITS, NW = 2*SW + 18) before out_valid rises, and skips the
// division for constant truth; a last pair stalls the input while the queue is full
// synchronous active-low reset clears the run sums, pair count, queue and output valid

module r_squared_score_unit_top
  import rsq_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_true_value,
  input  logic signed [SAMPLE_BITS-1:0] in_pred_value,
  input  logic                          in_last_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SCORE_W-1:0]     out_r2_score,
  output logic                          out_constant_truth,
  output logic                          out_score_saturated,
  output logic [COUNT_BITS-1:0]         out_pair_count
);

  localparam int ENTRY_W = COUNT_BITS + (SAMPLE_BITS + COUNT_BITS)
                         + 2 * (2 * SAMPLE_BITS + COUNT_BITS);

  logic               push, full, pop, empty;
  logic [ENTRY_W-1:0] push_data, pop_data;
  logic [SCORE_W-1:0] score;

  // accumulator front
  rsq_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_true_value (in_true_value),
    .in_pred_value (in_pred_value),
    .in_last_item  (in_last_item),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  // finished-run queue
  rsq_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_data),
    .full    (full),
    .rd_en   (pop),
    .rd_data (pop_data),
    .empty   (empty)
  );

  // score finisher
  rsq_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .empty               (empty),
    .rd_data             (pop_data),
    .rd_en               (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_r2_score        (score),
    .out_constant_truth  (out_constant_truth),
    .out_score_saturated (out_score_saturated),
    .out_pair_count      (out_pair_count)
  );

  assign out_r2_score = $signed(score);

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rsq_pkg::*;

  localparam int  SAMPLE_W   = 16;
  localparam int  COUNT_W    = 16;
  localparam int  RAND_ITEMS = 1800;
  localparam int  HOLD_CYC   = 600;
  // drain wait after the last expected result has come back
  localparam int  DRAIN_CYC  = 300;
  localparam int  DIR_N      = 24;
  localparam int  SHOW_MAX   = 10;
  localparam logic [COUNT_W-1:0] COUNT_FULL = '1;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               flat;
    logic               sat;
    logic [COUNT_W-1:0] cnt;
  } r2_result_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] t;
    logic signed [SAMPLE_W-1:0] p;
    logic                       last;
    bit                         typed;
    r2_result_t                 res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_true_value = '0;
  logic signed [SAMPLE_W-1:0] in_pred_value = '0;
  logic in_last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SCORE_W-1:0] out_r2_score;
  logic out_constant_truth;
  logic out_score_saturated;
  logic [COUNT_W-1:0] out_pair_count;

  // predictor state for the open run
  logic [COUNT_W-1:0] run_pairs = '0;
  longint             run_sum = 0;
  logic [63:0]        run_sum_sq = '0;
  logic [63:0]        run_res_sq = '0;

  r2_result_t r2_expected_q[$];
  r2_result_t rx_got;
  r2_result_t rx_want;
  stim_row_t  dir_tbl[DIR_N];

  int err_cnt = 0;
  int mis_cnt = 0;
  int rx_wait = 0;
  bit rx_idle_en = 1'b1;
  bit tx_idle_en = 1'b1;
  bit hold_go = 1'b0;
  logic hold_rx = 1'b0;

  r_squared_score_unit_top #(
    .SAMPLE_BITS(SAMPLE_W),
    .COUNT_BITS (COUNT_W)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_true_value      (in_true_value),
    .in_pred_value      (in_pred_value),
    .in_last_item       (in_last_item),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_r2_score       (out_r2_score),
    .out_constant_truth (out_constant_truth),
    .out_score_saturated(out_score_saturated),
    .out_pair_count     (out_pair_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // fold one accepted pair into the run sums, score the run on its last pair
  task automatic accumulate_pair(input logic signed [SAMPLE_W-1:0] t,
                                 input logic signed [SAMPLE_W-1:0] p,
                                 input logic last, input bit use_fixed,
                                 input r2_result_t fixed);
    longint       tl;
    longint       dl;
    logic [63:0]  sum_mag;
    logic [127:0] n_sq;
    logic [127:0] s_sq;
    logic [127:0] spread;
    logic [127:0] num;
    logic [127:0] quo;
    r2_result_t   res;
    tl = t;
    dl = tl - longint'(p);
    // a full counter drops the pair
    if (run_pairs != COUNT_FULL) begin
      run_pairs  = run_pairs + 1'b1;
      run_sum    = run_sum + tl;
      run_sum_sq = run_sum_sq + 64'(tl * tl);
      run_res_sq = run_res_sq + 64'(dl * dl);
    end
    if (last) begin
      sum_mag = (run_sum < 0) ? 64'(-run_sum) : 64'(run_sum);
      n_sq    = 128'(run_sum_sq) * 128'(run_pairs);
      s_sq    = 128'(sum_mag) * 128'(sum_mag);
      spread  = (n_sq >= s_sq) ? n_sq - s_sq : 128'd0;
      res.cnt  = run_pairs;
      res.flat = 1'b0;
      res.sat  = 1'b0;
      if (spread == 128'd0) begin
        // constant truth: score pinned to 1.0
        res.flat  = 1'b1;
        res.score = ONE_Q;
      end else begin
        // ratio in q16.16, rounded to nearest with ties up
        num = ((128'(run_res_sq) * 128'(run_pairs)) << (FRAC_BITS + 1)) + spread;
        quo = num / (spread << 1);
        if (quo > 128'(SAT_LIMIT)) begin
          res.sat   = 1'b1;
          res.score = SCORE_MIN;
        end else begin
          res.score = ONE_Q - quo[SCORE_W-1:0];
        end
      end
      r2_expected_q.push_back(use_fixed ? fixed : res);
      run_pairs  = '0;
      run_sum    = 0;
      run_sum_sq = '0;
      run_res_sq = '0;
    end
  endtask

  // offer one pair after a random gap and wait for its transfer
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] t,
                           input logic signed [SAMPLE_W-1:0] p,
                           input logic last, input bit use_fixed,
                           input r2_result_t fixed);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_true_value <= t;
    in_pred_value <= p;
    in_last_item  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accumulate_pair(t, p, last, use_fixed, fixed);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] edge_sample();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // result side: check each transfer, then stall for a random count
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      rx_got = '{out_r2_score, out_constant_truth, out_score_saturated, out_pair_count};
      if (r2_expected_q.size() == 0) begin
        err_cnt++;
        mis_cnt++;
        if (mis_cnt <= SHOW_MAX)
          $display("%0t: unexpected result score=%h flat=%b sat=%b count=%0d", $realtime,
                   rx_got.score, rx_got.flat, rx_got.sat, rx_got.cnt);
      end else begin
        rx_want = r2_expected_q.pop_front();
        if (rx_got.score !== rx_want.score || rx_got.flat !== rx_want.flat ||
            rx_got.sat !== rx_want.sat || rx_got.cnt !== rx_want.cnt) begin
          err_cnt++;
          mis_cnt++;
          if (mis_cnt <= SHOW_MAX)
            $display("%0t: mismatch exp %h/%b/%b/%0d got %h/%b/%b/%0d",
                     $realtime, rx_want.score, rx_want.flat, rx_want.sat, rx_want.cnt,
                     rx_got.score, rx_got.flat, rx_got.sat, rx_got.cnt);
        end
      end
      if ($urandom_range(0, 7) == 0) rx_idle_en = !rx_idle_en;
      rx_wait = rx_idle_en ? $urandom_range(0, 7) : 0;
    end
    out_stall <= hold_rx || (rx_wait != 0);
    if (rx_wait != 0) rx_wait--;
  end

  // long receiver hold-off so the result queue fills and the input stalls
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // stimulus
  initial begin : stim
    int                         run_len;
    int                         mode;
    int                         sent;
    logic signed [SAMPLE_W-1:0] t;
    logic signed [SAMPLE_W-1:0] p;
    logic signed [SAMPLE_W-1:0] t_base;
    logic                       last;
    r2_result_t                 none;
    none = '0;

    // directed rows: single pairs, extremes, perfect fit, saturation, flat truth
    dir_tbl = '{
      '{16'sd0,      16'sd0,      1'b1, 1'b1, '{ONE_Q,     1'b1, 1'b0, 16'd1}},
      '{-16'sd32768, 16'sd32767,  1'b1, 1'b1, '{ONE_Q,     1'b1, 1'b0, 16'd1}},
      '{16'sd32767,  16'sd32767,  1'b0, 1'b0, '0},
      '{-16'sd32768, -16'sd32768, 1'b1, 1'b1, '{ONE_Q,     1'b0, 1'b0, 16'd2}},
      '{16'sd0,      16'sd32767,  1'b0, 1'b0, '0},
      '{16'sd1,      -16'sd32768, 1'b1, 1'b1, '{SCORE_MIN, 1'b0, 1'b1, 16'd2}},
      '{-16'sd1,     16'sd0,      1'b0, 1'b0, '0},
      '{16'sd1,      16'sd0,      1'b1, 1'b1, '{32'd0,     1'b0, 1'b0, 16'd2}},
      '{16'sd5,      -16'sd7,     1'b0, 1'b0, '0},
      '{16'sd5,      16'sd100,    1'b0, 1'b0, '0},
      '{16'sd5,      16'sd5,      1'b1, 1'b1, '{ONE_Q,     1'b1, 1'b0, 16'd3}},
      '{16'sd3,      16'sd2,      1'b0, 1'b0, '0},
      '{-16'sd4,     -16'sd1,     1'b0, 1'b0, '0},
      '{16'sd10,     16'sd12,     1'b0, 1'b0, '0},
      '{16'sd7,      16'sd7,      1'b1, 1'b0, '0},
      '{16'sd32767,  -16'sd32768, 1'b0, 1'b0, '0},
      '{-16'sd32768, 16'sd32767,  1'b0, 1'b0, '0},
      '{16'sd100,    -16'sd100,   1'b1, 1'b0, '0},
      '{16'sd1,      16'sd2,      1'b0, 1'b0, '0},
      '{16'sd2,      16'sd1,      1'b0, 1'b0, '0},
      '{16'sd3,      16'sd5,      1'b0, 1'b0, '0},
      '{16'sd4,      16'sd4,      1'b1, 1'b0, '0},
      '{-16'sd32768, -16'sd32767, 1'b0, 1'b0, '0},
      '{16'sd32767,  16'sd32766,  1'b1, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_pair(dir_tbl[i].t, dir_tbl[i].p, dir_tbl[i].last, dir_tbl[i].typed, dir_tbl[i].res);
    // sender pauses until every result is back
    in_valid <= 1'b0;
    while (r2_expected_q.size() != 0) @(posedge clk);

    // short runs back to back while the receiver holds off
    tx_idle_en = 1'b0;
    hold_go = 1'b1;
    for (int i = 0; i < 30; i++) begin
      run_len = $urandom_range(1, 3);
      for (int j = 0; j < run_len; j++)
        send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom), (j == run_len - 1), 1'b0, none);
    end

    // random runs of mixed length and fit quality
    sent = 0;
    while (sent < RAND_ITEMS) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       run_len = 1;
        7:       run_len = $urandom_range(25, 60);
        default: run_len = $urandom_range(2, 24);
      endcase
      mode   = $urandom_range(0, 4);
      t_base = SAMPLE_W'($urandom);
      for (int j = 0; j < run_len; j++) begin
        case (mode)
          0: begin
            t = SAMPLE_W'($urandom);
            p = SAMPLE_W'($urandom);
          end
          1: begin
            // close fit with small noise
            t = SAMPLE_W'($urandom);
            p = t + SAMPLE_W'($urandom_range(0, 16)) - 16'sd8;
          end
          2: begin
            t = t_base;
            p = SAMPLE_W'($urandom);
          end
          3: begin
            t = SAMPLE_W'($urandom_range(0, 16)) - 16'sd8;
            p = SAMPLE_W'($urandom_range(0, 16)) - 16'sd8;
          end
          default: begin
            t = edge_sample();
            p = edge_sample();
          end
        endcase
        last = (j == run_len - 1);
        send_pair(t, p, last, 1'b0, none);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (r2_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
